@@ design/rlcr_pkg.sv @@
// Package for the run-length constrained repaint block.
// Holds sizes, field widths, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none
package rlcr_pkg;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_AW      = $clog2(MAX_COLUMNS);
  localparam int DP_AW       = $clog2(MAX_COLUMNS + 1);
  localparam int CFG_W       = 11;
  localparam int CNT_W       = $clog2(MAX_ROWS + 1);
  localparam int PFX_W       = 21;
  localparam int COST_W      = 22;
  localparam int DP_W        = PFX_W + 2 * COST_W;
  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

  localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] REG_MIN_RUN      = 2'd2;
  localparam logic [1:0] REG_MAX_RUN      = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DRAIN, ST_PFX_RD, ST_PFX_WR,
    ST_DP_RDI, ST_DP_GETI, ST_DP_RDJ, ST_DP_CMP, ST_DP_WR
  } state_t;
endpackage
`default_nettype wire

@@ design/rlcr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module rlcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/run_length_constrained_repaint_top.sv @@
// Top level of the run-length constrained repaint block.
// Depends on rlcr_pkg and rlcr_ram (column counts and the dynamic program table).
//
// Pixels are taken one per cycle while busy is low. After the pixel marked last,
// busy stays high while the block sums the column counts, runs the dynamic
// program (one table entry read at a time, through the single read port of the
// table memory) and then clears the 1024 column counts; out_valid strobes in the
// first of those clearing cycles. The same clearing pass runs after reset. The
// result cannot be stalled and must be taken in its strobe cycle.
`default_nettype none
module run_length_constrained_repaint_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_pixel_dark,
  input  wire logic                      in_last_pixel,
  output logic                           out_valid,
  output logic [20:0]                    out_min_flips,
  output logic                           out_no_solution,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [rlcr_pkg::CFG_W-1:0] cfg_wdata
);
  import rlcr_pkg::*;

  state_t state_r, state_nxt;
  logic [CFG_W-1:0] cols_cfg_r, rows_cfg_r, lo_cfg_r, hi_cfg_r;
  logic [COL_AW-1:0] pos_r, pos_nxt;
  logic v1_r, wv_r, d1_r;
  logic [COL_AW-1:0] a1_r, wa_r;
  logic [CNT_W-1:0] wd_r;
  logic [DP_AW-1:0] k_r, k_nxt, i_r, i_nxt, w_r, w_nxt;
  logic [PFX_W-1:0] sum_r, sum_nxt, pi_r, pi_nxt, rw_r, rw_nxt, rwlo_r;
  logic [COST_W-1:0] bl_r, bl_nxt, bd_r, bd_nxt;
  logic ov_r, ov_nxt, on_r, on_nxt;
  logic [20:0] of_r, of_nxt;

  logic [CFG_W-1:0] cols, rows, lo;
  logic [COL_AW-1:0] pos_use, pos_next;
  logic [CFG_W-1:0] pos_inc;
  logic accept;
  logic [CNT_W-1:0] q_eff, cnt_new, d_clamp;
  logic [2*CFG_W-1:0] prod;

  logic dk_we;
  logic [COL_AW-1:0] dk_waddr, dk_raddr;
  logic [CNT_W-1:0] dk_wdata, dk_rdata;
  logic dp_we;
  logic [DP_AW-1:0] dp_waddr, dp_raddr;
  logic [DP_W-1:0] dp_wdata, dp_rdata;

  logic [PFX_W-1:0] pj, dark, light;
  logic [COST_W-1:0] clj, cdj, cand_l, cand_d, best;
  logic [DP_AW-1:0] wn;

  rlcr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLUMNS)) u_dark_ram (
    .clk(clk), .we(dk_we), .waddr(dk_waddr), .wdata(dk_wdata),
    .raddr(dk_raddr), .rdata(dk_rdata)
  );

  rlcr_ram #(.WIDTH(DP_W), .DEPTH(MAX_COLUMNS + 1)) u_dp_ram (
    .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
    .raddr(dp_raddr), .rdata(dp_rdata)
  );

  assign cols = (cols_cfg_r == '0) ? CFG_W'(1) :
                (cols_cfg_r > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cols_cfg_r;
  assign rows = (rows_cfg_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_cfg_r;
  assign lo   = (lo_cfg_r == '0) ? CFG_W'(1) : lo_cfg_r;
  assign prod = rows * lo;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign pos_use  = ({1'b0, pos_r} >= cols) ? '0 : pos_r;
  assign pos_inc  = {1'b0, pos_use} + CFG_W'(1);
  assign pos_next = (pos_inc >= cols) ? '0 : pos_inc[COL_AW-1:0];

  // forward the write that the read of this entry missed
  assign q_eff   = (wv_r && wa_r == a1_r) ? wd_r : dk_rdata;
  assign cnt_new = (d1_r && q_eff < CNT_W'(MAX_ROWS)) ? q_eff + CNT_W'(1) : q_eff;
  assign d_clamp = (dk_rdata > CNT_W'(rows)) ? CNT_W'(rows) : dk_rdata;

  assign pj     = dp_rdata[DP_W-1 -: PFX_W];
  assign clj    = dp_rdata[2*COST_W-1 -: COST_W];
  assign cdj    = dp_rdata[COST_W-1:0];
  assign dark   = pi_r - pj;
  assign light  = rw_r - dark;
  assign cand_d = cdj + COST_W'(dark);
  assign cand_l = clj + COST_W'(light);
  assign wn     = w_r + DP_AW'(1);
  assign best   = (bl_r < bd_r) ? bl_r : bd_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    w_nxt     = w_r;
    sum_nxt   = sum_r;
    pi_nxt    = pi_r;
    rw_nxt    = rw_r;
    bl_nxt    = bl_r;
    bd_nxt    = bd_r;
    ov_nxt    = 1'b0;
    of_nxt    = of_r;
    on_nxt    = on_r;
    dk_we     = v1_r;
    dk_waddr  = a1_r;
    dk_wdata  = cnt_new;
    dk_raddr  = pos_use;
    dp_we     = 1'b0;
    dp_waddr  = '0;
    dp_wdata  = '0;
    dp_raddr  = i_r;
    case (state_r)
      ST_CLEAR: begin
        dk_we    = 1'b1;
        dk_waddr = k_r[COL_AW-1:0];
        dk_wdata = '0;
        k_nxt    = k_r + DP_AW'(1);
        if (k_r == DP_AW'(MAX_COLUMNS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          pos_nxt = pos_next;
          if (in_last_pixel) begin
            pos_nxt   = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        dp_we     = 1'b1;
        k_nxt     = '0;
        sum_nxt   = '0;
        state_nxt = ST_PFX_RD;
      end
      ST_PFX_RD: begin
        dk_raddr  = k_r[COL_AW-1:0];
        state_nxt = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        sum_nxt  = sum_r + PFX_W'(d_clamp);
        dp_we    = 1'b1;
        dp_waddr = k_r + DP_AW'(1);
        dp_wdata = {sum_nxt, COST_INF, COST_INF};
        k_nxt    = k_r + DP_AW'(1);
        if (k_nxt == DP_AW'(cols)) begin
          i_nxt     = DP_AW'(1);
          state_nxt = ST_DP_RDI;
        end else begin
          state_nxt = ST_PFX_RD;
        end
      end
      ST_DP_RDI: begin
        dp_raddr  = i_r;
        state_nxt = ST_DP_GETI;
      end
      ST_DP_GETI: begin
        pi_nxt = pj;
        bl_nxt = COST_INF;
        bd_nxt = COST_INF;
        w_nxt  = DP_AW'(lo);
        rw_nxt = rwlo_r;
        if (lo > hi_cfg_r || {1'b0, lo} > {1'b0, i_r}) begin
          state_nxt = ST_DP_WR;
        end else begin
          state_nxt = ST_DP_RDJ;
        end
      end
      ST_DP_RDJ: begin
        dp_raddr  = i_r - w_r;
        state_nxt = ST_DP_CMP;
      end
      ST_DP_CMP: begin
        if (cdj != COST_INF && cand_d < bl_r) begin
          bl_nxt = cand_d;
        end
        if (clj != COST_INF && cand_l < bd_r) begin
          bd_nxt = cand_l;
        end
        w_nxt  = wn;
        rw_nxt = rw_r + PFX_W'(rows);
        if ({1'b0, wn} > {1'b0, hi_cfg_r} || wn > i_r) begin
          state_nxt = ST_DP_WR;
        end else begin
          state_nxt = ST_DP_RDJ;
        end
      end
      ST_DP_WR: begin
        dp_we    = 1'b1;
        dp_waddr = i_r;
        dp_wdata = {pi_r, bl_r, bd_r};
        if (i_r == DP_AW'(cols)) begin
          ov_nxt    = 1'b1;
          of_nxt    = (best == COST_INF) ? '0 : best[20:0];
          on_nxt    = (best == COST_INF);
          k_nxt     = '0;
          state_nxt = ST_CLEAR;
        end else begin
          i_nxt     = i_r + DP_AW'(1);
          state_nxt = ST_DP_RDI;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        k_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      k_r        <= '0;
      pos_r      <= '0;
      v1_r       <= 1'b0;
      wv_r       <= 1'b0;
      ov_r       <= 1'b0;
      cols_cfg_r <= CFG_W'(1);
      rows_cfg_r <= CFG_W'(1);
      lo_cfg_r   <= CFG_W'(1);
      hi_cfg_r   <= CFG_W'(1);
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      v1_r    <= accept;
      wv_r    <= v1_r;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMN_COUNT: cols_cfg_r <= cfg_wdata;
          REG_ROW_COUNT:    rows_cfg_r <= cfg_wdata;
          REG_MIN_RUN:      lo_cfg_r   <= cfg_wdata;
          REG_MAX_RUN:      hi_cfg_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= pos_use;
    d1_r   <= in_pixel_dark;
    wa_r   <= a1_r;
    wd_r   <= cnt_new;
    i_r    <= i_nxt;
    w_r    <= w_nxt;
    sum_r  <= sum_nxt;
    pi_r   <= pi_nxt;
    rw_r   <= rw_nxt;
    rwlo_r <= prod[PFX_W-1:0];
    bl_r   <= bl_nxt;
    bd_r   <= bd_nxt;
    of_r   <= of_nxt;
    on_r   <= on_nxt;
  end

  assign out_valid       = ov_r;
  assign out_min_flips   = of_r;
  assign out_no_solution = on_r;
endmodule
`default_nettype wire
